// ----- hw/rtl/texture_unit_lru_binder_core_defines.svh -----
// Assertion macros for the texture unit LRU binder.
// Define ASSERT_OFF to compile every check out.
`ifndef TEXTURE_UNIT_LRU_BINDER_CORE_DEFINES_SVH
`define TEXTURE_UNIT_LRU_BINDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define TULB_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("tulb check failed");
// Checked at every edge, reset included.
`define TULB_ASSERT_ALWAYS(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("tulb check failed");
`else
`define TULB_ASSERT(name, clock, reset, prop)
`define TULB_ASSERT_ALWAYS(name, clock, prop)
`endif

`endif

// ----- hw/rtl/tulb_pkg.sv -----
// Shared constants and types for the texture unit LRU binder.
// Used by the controller, the datapath and the top level.
package tulb_pkg;

  localparam int NUM_UNITS  = 16;
  localparam int NAME_WIDTH = 32;

  localparam int IDX_W = $clog2(NUM_UNITS);
  localparam int CNT_W = $clog2(NUM_UNITS + 1);

  localparam int ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam int IN_NAME_W  = 32;
  localparam int OUT_NAME_W = 32;
  localparam int UNIT_W     = 4;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - (UNIT_W + 2 + OUT_NAME_W);

  // One-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch request
    logic look;     // compare tags against the request
    logic pick;     // search the LRU order for hit and victim
    logic commit;   // update cache, load result register
  } cmd_t;

endpackage

// ----- hw/rtl/tulb_ctrl.sv -----
// Controller for the texture unit LRU binder: sequences one request through
// compare, search and commit, and owns the stream handshakes. Uses tulb_pkg.
module tulb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output tulb_pkg::cmd_t cmd
);
  import tulb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PICK,
    ST_COMMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd         = '0;
    cmd.capture = (state == ST_IDLE) && s_tvalid && s_tready;
    cmd.look    = (state == ST_LOOK);
    cmd.pick    = (state == ST_PICK);
    cmd.commit  = (state == ST_COMMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once transferred; a commit reloads it
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state    <= ST_LOOK;
            s_tready <= 1'b0;
          end
        end
        ST_LOOK: begin
          state <= ST_PICK;
        end
        ST_PICK: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          // hold until the result register is free
          if (cmd.commit) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/tulb_dp.sv -----
// Datapath for the texture unit LRU binder: tag and valid registers, LRU
// order list, active unit count and the result register. Uses tulb_pkg.
module tulb_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  tulb_pkg::cmd_t                     cmd,
  input  logic                               cfg_wr_en,
  input  logic [tulb_pkg::ACTIVE_W-1:0]      cfg_wr_data,
  input  logic [tulb_pkg::IN_NAME_W-1:0]     req_name_in,
  input  logic                               req_kind_in,
  output logic [tulb_pkg::M_TDATA_W-1:0]     res_data,
  output logic                               res_kind
);
  import tulb_pkg::*;

  logic [NAME_WIDTH-1:0] tag [NUM_UNITS];
  logic [NUM_UNITS-1:0]  valid;
  logic [IDX_W-1:0]      lru [NUM_UNITS];
  logic [ACTIVE_W-1:0]   active;

  logic [NAME_WIDTH-1:0] req_name;
  logic                  req_kind;
  logic [NUM_UNITS-1:0]  unit_match;
  logic [NUM_UNITS-1:0]  unit_live;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_pos;
  logic [IDX_W-1:0]      victim_pos;

  logic [CNT_W-1:0]      n_eff;
  logic [NUM_UNITS-1:0]  unit_match_next;
  logic [NUM_UNITS-1:0]  unit_live_next;
  logic                  hit_found_next;
  logic [IDX_W-1:0]      hit_pos_next;
  logic [IDX_W-1:0]      victim_pos_next;
  logic [IDX_W-1:0]      sel_pos;
  logic [IDX_W-1:0]      sel_unit;
  logic                  ev_valid;
  logic [NAME_WIDTH-1:0] ev_name;
  logic [IDX_W-1:0]      lru_next [NUM_UNITS];

  // clamp the configured count to 1..NUM_UNITS
  always_comb begin
    if (active == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(active) > NUM_UNITS) begin
      n_eff = CNT_W'(NUM_UNITS);
    end else begin
      n_eff = CNT_W'(active);
    end
  end

  // per-unit tag compare
  always_comb begin
    for (int u = 0; u < NUM_UNITS; u++) begin
      unit_live_next[u]  = CNT_W'(u) < n_eff;
      unit_match_next[u] = valid[u] && (tag[u] == req_name) && unit_live_next[u];
    end
  end

  // first hit and first live unit in LRU order, oldest first
  always_comb begin
    hit_found_next  = 1'b0;
    hit_pos_next    = '0;
    victim_pos_next = '0;
    for (int p = NUM_UNITS - 1; p >= 0; p--) begin
      if (unit_match[lru[p]]) begin
        hit_found_next = 1'b1;
        hit_pos_next   = IDX_W'(p);
      end
      if (unit_live[lru[p]]) begin
        victim_pos_next = IDX_W'(p);
      end
    end
  end

  // move the chosen unit to the newest end
  always_comb begin
    sel_pos  = hit_found ? hit_pos : victim_pos;
    sel_unit = lru[sel_pos];
    ev_valid = !hit_found && valid[sel_unit];
    ev_name  = ev_valid ? tag[sel_unit] : '0;
    for (int i = 0; i < NUM_UNITS; i++) begin
      if (IDX_W'(i) < sel_pos) begin
        lru_next[i] = lru[i];
      end else if (i == NUM_UNITS - 1) begin
        lru_next[i] = sel_unit;
      end else begin
        lru_next[i] = lru[(i + 1) % NUM_UNITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RESET;
      valid  <= '0;
      for (int i = 0; i < NUM_UNITS; i++) begin
        lru[i] <= IDX_W'(i);
      end
    end else if (cfg_wr_en) begin
      // new unit count: start over with an empty cache
      active <= cfg_wr_data;
      valid  <= '0;
      for (int i = 0; i < NUM_UNITS; i++) begin
        lru[i] <= IDX_W'(i);
      end
    end else if (cmd.commit) begin
      if (!hit_found) begin
        valid[sel_unit] <= 1'b1;
      end
      for (int i = 0; i < NUM_UNITS; i++) begin
        lru[i] <= lru_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_found) begin
      tag[sel_unit] <= req_name;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_name <= NAME_WIDTH'(req_name_in);
      req_kind <= req_kind_in;
    end
    if (cmd.look) begin
      unit_match <= unit_match_next;
      unit_live  <= unit_live_next;
    end
    if (cmd.pick) begin
      hit_found  <= hit_found_next;
      hit_pos    <= hit_pos_next;
      victim_pos <= victim_pos_next;
    end
    if (cmd.commit) begin
      res_data <= {{M_PAD_W{1'b0}}, OUT_NAME_W'(ev_name), ev_valid, !hit_found,
                   UNIT_W'(sel_unit)};
      res_kind <= req_kind;
    end
  end

endmodule

// ----- hw/rtl/texture_unit_lru_binder_core.sv -----
// Texture unit binder: fully associative texture name cache over the
// texture units with least-recently-used replacement.
// Input stream (s_*): one bind request per transfer. tdata holds the texture
// name, tuser the texture kind.
// Output stream (m_*): one result per request, in order. tdata holds the unit,
// bind_needed, evicted_valid and the evicted name; tuser echoes the kind.
// Configuration: cfg_wr_en with cfg_wr_data writes the active unit count
// (0 acts as 1, values above the unit count act as the unit count) and empties
// the cache. Write it only while no request is in flight.
// Timing: after a request transfers, the block runs the tag compare, LRU search
// and commit steps in order and loads the result at commit; it takes the next
// request only after that commit, so one request is in flight at a time.
// The result register lets the next request enter while a result waits; a
// stalled receiver holds the block in its commit step until m_tready.
// Reset (rst, synchronous): all units invalid, order ascending with unit 0
// oldest, sixteen units active, no result pending.
`include "texture_unit_lru_binder_core_defines.svh"

module texture_unit_lru_binder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tulb_pkg::S_TDATA_W-1:0] s_tdata,      // [31:0] texture_name
  input  logic                           s_tuser,      // [0] texture_kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] unit, [4] bind_needed, [5] evicted_valid, [37:6] evicted_name, [39:38] zero
  output logic [tulb_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser,      // [0] bind_kind
  input  logic                           cfg_wr_en,
  input  logic [tulb_pkg::ACTIVE_W-1:0]  cfg_wr_data
);
  import tulb_pkg::*;

  cmd_t cmd;

  tulb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tulb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_name_in (s_tdata[IN_NAME_W-1:0]),
    .req_kind_in (s_tuser),
    .res_data    (m_tdata),
    .res_kind    (m_tuser)
  );

  `TULB_ASSERT(a_one_in_flight, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  `TULB_ASSERT(a_commit_shows, clk, rst, cmd.commit |=> m_tvalid)
  `TULB_ASSERT(a_look_then_pick, clk, rst, cmd.look |=> cmd.pick)
  `TULB_ASSERT(a_cmd_single, clk, rst, $onehot0(cmd))
  `TULB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (s_tready && !m_tvalid))

endmodule
